// ===== rtl/string_to_unsigned_parser_core_macros.svh =====
// Assertion macros used by the parser top level
`ifndef STRING_TO_UNSIGNED_PARSER_CORE_MACROS_SVH
`define STRING_TO_UNSIGNED_PARSER_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low
`define S2U_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low
`define S2U_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/s2u_pkg.sv =====
// Types and constants shared by the string to unsigned parser modules
package s2u_pkg;

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int BASE_W  = 6;

    // parse phase codes
    localparam logic [1:0] PH_DONE   = 2'd0;
    localparam logic [1:0] PH_BLANK  = 2'd1;
    localparam logic [1:0] PH_ZERO   = 2'd2;
    localparam logic [1:0] PH_DIGITS = 2'd3;

    typedef struct packed {
        logic [1:0]         phase;
        logic [VALUE_W-1:0] acc;
        logic [BASE_W-1:0]  wbase;
    } parse_state_t;

    typedef struct packed {
        logic               emit;
        logic [VALUE_W-1:0] value;
    } parse_result_t;

endpackage

// ===== rtl/s2u_step.sv =====
// Per-character parse step: blank skip, prefix detection, digit decode, multiply-add
module s2u_step
    import s2u_pkg::*;
(
    input  parse_state_t        state_cur,
    input  logic [CHAR_W-1:0]   char_in,
    input  logic                start_in,
    input  logic [BASE_W-1:0]   cfg_base,
    output parse_state_t        state_next,
    output parse_result_t       result
);

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;
    localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

    parse_state_t       st;
    logic [BASE_W-1:0]  wb_eff;
    logic [BASE_W-1:0]  digit;
    logic               digit_hit;
    logic               is_blank;
    logic               auto_or_hex;
    logic               eval_digit;
    logic [VALUE_W-1:0] product;

    // digit decode; letters count from ten
    always_comb begin
        digit     = '0;
        digit_hit = 1'b0;
        if (char_in >= CH_0 && char_in <= CH_9) begin
            digit     = BASE_W'(char_in - CH_0);
            digit_hit = 1'b1;
        end else if (char_in >= CH_UA && char_in <= CH_UZ) begin
            digit     = BASE_W'(char_in - (CH_UA - LETTER_OFS));
            digit_hit = 1'b1;
        end else if (char_in >= CH_LA && char_in <= CH_LZ) begin
            digit     = BASE_W'(char_in - (CH_LA - LETTER_OFS));
            digit_hit = 1'b1;
        end
    end

    assign is_blank = (char_in == CH_SPACE) || (char_in >= CH_TAB && char_in <= CH_CR);

    always_comb begin
        st = state_cur;
        if (start_in) begin
            st.phase = PH_BLANK;
            st.acc   = '0;
            st.wbase = cfg_base;
        end
    end

    assign auto_or_hex = (st.wbase == '0) || (st.wbase == BASE_HEX);
    assign wb_eff      = (st.wbase == '0) ? BASE_DEC : st.wbase;
    assign product     = st.acc * VALUE_W'(wb_eff);

    always_comb begin
        state_next   = st;
        result.emit  = 1'b0;
        result.value = st.acc;
        eval_digit   = 1'b0;
        case (st.phase)
            PH_DONE: begin
                eval_digit = 1'b0;
            end
            PH_BLANK: begin
                if (is_blank) begin
                    eval_digit = 1'b0;
                end else if (char_in == CH_0 && auto_or_hex) begin
                    state_next.phase = PH_ZERO;
                end else begin
                    eval_digit = 1'b1;
                end
            end
            PH_ZERO: begin
                if (char_in == CH_LX || char_in == CH_UX) begin
                    state_next.wbase = BASE_HEX;
                    state_next.phase = PH_DIGITS;
                end else begin
                    // the held '0' adds nothing, accumulator is already zero
                    eval_digit = 1'b1;
                end
            end
            PH_DIGITS: begin
                eval_digit = 1'b1;
            end
            default: begin
                eval_digit = 1'b0;
            end
        endcase

        if (eval_digit) begin
            state_next.wbase = wb_eff;
            if (!digit_hit || digit >= wb_eff) begin
                state_next.phase = PH_DONE;
                result.emit      = 1'b1;
            end else begin
                state_next.phase = PH_DIGITS;
                state_next.acc   = product + VALUE_W'(digit);
            end
        end
    end

endmodule

// ===== rtl/string_to_unsigned_parser_core.sv =====
// String to unsigned parser top level: request registers, parse state, result register
//
//  Channel   Direction  Payload                                  Handshake
//  s_*       in         tdata: character; tuser: string_start    tvalid/tready
//  m_*       out        tdata: parsed_value                      tvalid/tready
//  cfg_*     in         cfg_wr_data: number_base                 cfg_wr_en only
//
// One character per cycle unless the result stalls; held in input, then result reg.
// The multiply-add of the accumulator by the base is combinational.
// Reset (aresetn low, synchronous) leaves the parser waiting for a start, base 0.
// A stalled result register holds the following character in the input register.
module string_to_unsigned_parser_core
    import s2u_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CHAR_W-1:0]  s_tdata,      // [7:0] character
    input  logic [0:0]         s_tuser,      // [0] string_start
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] m_tdata,      // [31:0] parsed_value
    input  logic               cfg_wr_en,
    input  logic [BASE_W-1:0]  cfg_wr_data
);

`include "string_to_unsigned_parser_core_macros.svh"

    logic                in_valid_reg;
    logic [CHAR_W-1:0]   in_char_reg;
    logic                in_start_reg;
    parse_state_t        state_reg;
    parse_state_t        state_next;
    parse_result_t       step_res;
    logic                m_valid_reg;
    logic [VALUE_W-1:0]  m_data_reg;
    logic [BASE_W-1:0]   base_reg;
    logic                consume;

    s2u_step u_step (
        .state_cur  (state_reg),
        .char_in    (in_char_reg),
        .start_in   (in_start_reg),
        .cfg_base   (base_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    // held character moves on once the result slot is free or draining
    assign consume  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            in_start_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            base_reg        <= '0;
            state_reg.phase <= PH_DONE;
            state_reg.acc   <= '0;
            state_reg.wbase <= '0;
        end else begin
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
                in_start_reg <= s_tvalid && s_tuser[0];
            end
            if (consume) begin
                state_reg <= state_next;
            end
            if (consume && step_res.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
        end
        if (consume && step_res.emit) begin
            m_data_reg <= step_res.value;
        end
    end

    `S2U_ASSERT_NOW(a_ready_when_empty, !in_valid_reg, s_tready, "input register empty but not ready")
    `S2U_ASSERT_NEXT(a_held_char_kept, in_valid_reg && !consume, in_valid_reg && $stable(in_char_reg), "held character lost")
    `S2U_ASSERT_NEXT(a_done_after_emit, consume && step_res.emit, state_reg.phase == PH_DONE, "parse not closed after result")
    `S2U_ASSERT_NOW(a_quiet_when_done, consume && !in_start_reg && state_reg.phase == PH_DONE, !step_res.emit, "result after end of parse")

endmodule
